@@ rtl/core/dpb_pkg.sv @@
// Shared types and fixed-point constants for the depth pixel back-projection pipeline.
// Depends on nothing; imported by depth_pixel_backprojection.
package dpb_pkg;

    localparam int ROW_W      = 12;
    localparam int DEPTH_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int NUM_STAGES = 12;

    typedef struct packed {
        logic [11:0] pixel_row;
        logic [11:0] pixel_col;
        logic [15:0] depth_mm;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } pixel_t;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic [7:0]         point_red;
        logic [7:0]         point_green;
        logic [7:0]         point_blue;
    } point_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_FOCAL_X     = 3'd0,
        CFG_INV_FOCAL_Y     = 3'd1,
        CFG_PRINCIPAL_POINT = 3'd2,
        CFG_ROTATION_ROW0   = 3'd3,
        CFG_ROTATION_ROW1   = 3'd4,
        CFG_ROTATION_ROW2   = 3'd5,
        CFG_TRANSLATION_XY  = 3'd6,
        CFG_TRANSLATION_Z   = 3'd7
    } cfg_index_t;

    localparam logic [31:0] INV_FOCAL_RST = 32'd8589934;
    localparam logic [47:0] ROT_ROW0_RST  = 48'h0000_0000_4000;
    localparam logic [47:0] ROT_ROW1_RST  = 48'h0000_4000_0000;
    localparam logic [47:0] ROT_ROW2_RST  = 48'h4000_0000_0000;

    localparam logic [15:0] DEPTH_MIN_MM = 16'd10;
    localparam logic [15:0] DEPTH_MAX_MM = 16'd10000;

    // Exact quotient by the stride for 12-bit operands: q = (n * ceil(2^24 / S)) >> 24.
    localparam int MOD_SHIFT   = 24;
    localparam int MOD_RECIP_W = 25;

    // Camera z: round(depth * 65536 / 1000) = floor((depth * 8192 + 62) / 125).
    localparam int          ZW_W    = 27;
    localparam int          ZP_W    = 56;
    localparam int          Z_SHIFT = 35;
    localparam int          PZ_W    = 20;
    localparam logic [26:0] Z_BIAS  = 27'd62;
    localparam logic [28:0] Z_RECIP = 29'd274877907;

    // Camera x and y: round(q / (1000 * 2^20)) = floor(floor((q + half) / 2^23) / 125).
    localparam int          MD_W     = 30;
    localparam int          Q_W      = 62;
    localparam int          V_W      = 39;
    localparam int          XY_SHIFT = 23;
    localparam int          M_W      = 33;
    localparam int          RQ_SHIFT = 47;
    localparam logic [61:0] XY_HALF  = 62'd524288000;
    localparam logic [40:0] RQ       = 41'd1125899906843;
    localparam logic [19:0] RQ_HI    = RQ[40:21];
    localparam logic [20:0] RQ_LO    = RQ[20:0];

    localparam int P_W    = 34;
    localparam int PROD_W = 50;
    localparam int ACC_W  = 52;
    localparam int RND_W  = 38;
    localparam int SUM_W  = 39;

endpackage

@@ rtl/core/depth_pixel_backprojection.sv @@
// Top level of the depth pixel back-projection pipeline: filter, pinhole model, rigid transform.
// Depends on dpb_pkg for the beat types, register indexes and fixed-point constants.
//
// The block takes one pixel beat per clock while in_ready is high and returns a world point
// beat for each kept pixel; the pipeline has twelve register stages, and the output beat sits
// in the last one. Pixels off the stride grid or outside 10 mm to 10000 mm leave the pipeline
// after the first stage and produce no beat. Each stage advances when it is empty or the stage
// after it advances, so bubbles are squeezed out during a stall and in_ready drops only when
// every stage holds a beat and out_ready is low. The camera x and y division by 1000 * 2^20
// uses a constant reciprocal split into four partial products over three stages. Configuration
// must be written only while the pipeline is empty; the block itself does not enforce this.
module depth_pixel_backprojection #(
    parameter int STRIDE = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  dpb_pkg::pixel_t                     pixel,
    output logic                                out_valid,
    input  logic                                out_ready,
    output dpb_pkg::point_t                     point
);
    import dpb_pkg::*;

    localparam int STRIDE_W = $clog2(STRIDE + 1);
    localparam int MODP_W   = ROW_W + MOD_RECIP_W;
    localparam int CHK_W    = ROW_W + STRIDE_W;
    localparam logic [STRIDE_W-1:0]    STRIDE_V  = STRIDE_W'(STRIDE);
    localparam logic [MOD_RECIP_W-1:0] MOD_RECIP =
        MOD_RECIP_W'(((1 << MOD_SHIFT) + STRIDE - 1) / STRIDE);
    localparam logic [V_W-1:0] V_ZERO_INV = V_W'(XY_HALF >> XY_SHIFT);
    localparam logic signed [SUM_W-1:0] SAT_MAX = 39'sd2147483647;
    localparam logic signed [SUM_W-1:0] SAT_MIN = -39'sd2147483648;

    logic [31:0] inv_reg [2];
    logic [31:0] pp_reg;
    logic [47:0] rot_reg [3];
    logic [63:0] txy_reg;
    logic [31:0] tz_reg;

    logic [NUM_STAGES:1] stage_valid_reg;
    logic [NUM_STAGES:1] adv;
    logic                keep;

    rgb_t        rgb_reg [1:NUM_STAGES-1];
    logic [1:0]  neg_reg [1:7];
    logic [PZ_W-1:0] pz_reg [2:7];

    // Stage 1: offsets, stride quotients, depth window.
    logic [ROW_W-1:0]   row1_reg, col1_reg;
    logic [DEPTH_W-1:0] depth1_reg;
    logic               depth_ok_reg, depth_ok_next;
    logic [ROW_W-1:0]   qrow_reg, qrow_next, qcol_reg, qcol_next;
    logic [15:0]        mag_reg [2];
    logic [15:0]        mag_next [2];
    logic [1:0]         neg_next;
    rgb_t               rgb_next;

    // Stages 2 to 8: lateral magnitudes and camera point.
    logic [MD_W-1:0] md_reg [2];
    logic [MD_W-1:0] md_next [2];
    logic [PZ_W-1:0] pz_next;
    logic [Q_W-1:0]  q_reg [2];
    logic [Q_W-1:0]  q_next [2];
    logic [V_W-1:0]  vq_reg [2];
    logic [V_W-1:0]  vq_next [2];
    logic [38:0]     hh_reg [2];
    logic [38:0]     hh_next [2];
    logic [39:0]     hl_reg [2];
    logic [39:0]     hl_next [2];
    logic [39:0]     lh_reg [2];
    logic [39:0]     lh_next [2];
    logic [40:0]     ll_reg [2];
    logic [40:0]     ll_next [2];
    logic [60:0]     a_reg [2];
    logic [60:0]     a_next [2];
    logic [61:0]     b_reg [2];
    logic [61:0]     b_next [2];
    logic [M_W-1:0]  m_reg [2];
    logic [M_W-1:0]  m_next [2];
    logic signed [P_W-1:0] p_reg [3];
    logic signed [P_W-1:0] p_next [3];

    // Stages 9 to 12: rigid transform.
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic signed [ACC_W-1:0]  acc_reg [3];
    logic signed [ACC_W-1:0]  acc_next [3];
    logic signed [RND_W-1:0]  rnd_reg [3];
    logic signed [RND_W-1:0]  rnd_next [3];
    point_t                   point_reg, point_next;

    always_comb
    begin
        adv[NUM_STAGES] = !stage_valid_reg[NUM_STAGES] || out_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            adv[k] = !stage_valid_reg[k] || adv[k + 1];
        end
    end

    assign in_ready  = adv[1];
    assign out_valid = stage_valid_reg[NUM_STAGES];
    assign point     = point_reg;

    always_comb
    begin
        logic [16:0]       off [2];
        logic [MODP_W-1:0] prow, pcol;
        off[0] = {1'b0, pixel.pixel_col, 4'b0000} - {1'b0, pp_reg[15:0]};
        off[1] = {1'b0, pixel.pixel_row, 4'b0000} - {1'b0, pp_reg[31:16]};
        for (int l = 0; l < 2; l++)
        begin
            neg_next[l] = off[l][16];
            mag_next[l] = off[l][16] ? 16'(17'd0 - off[l]) : off[l][15:0];
        end
        prow = MODP_W'(pixel.pixel_row) * MODP_W'(MOD_RECIP);
        pcol = MODP_W'(pixel.pixel_col) * MODP_W'(MOD_RECIP);
        qrow_next = prow[MOD_SHIFT +: ROW_W];
        qcol_next = pcol[MOD_SHIFT +: ROW_W];
        depth_ok_next = (pixel.depth_mm >= DEPTH_MIN_MM) && (pixel.depth_mm <= DEPTH_MAX_MM);
        rgb_next.red   = pixel.red;
        rgb_next.green = pixel.green;
        rgb_next.blue  = pixel.blue;
    end

    always_comb
    begin
        logic [CHK_W-1:0] mrow, mcol;
        logic [ZW_W-1:0]  zw;
        logic [ZP_W-1:0]  zprod;
        mrow = CHK_W'(qrow_reg) * CHK_W'(STRIDE_V);
        mcol = CHK_W'(qcol_reg) * CHK_W'(STRIDE_V);
        keep = depth_ok_reg && (mrow == CHK_W'(row1_reg)) && (mcol == CHK_W'(col1_reg));
        for (int l = 0; l < 2; l++)
        begin
            md_next[l] = MD_W'(mag_reg[l]) * MD_W'(depth1_reg[13:0]);
        end
        zw      = ZW_W'({depth1_reg[13:0], 13'd0}) + Z_BIAS;
        zprod   = ZP_W'(zw) * ZP_W'(Z_RECIP);
        pz_next = zprod[Z_SHIFT +: PZ_W];
    end

    always_comb
    begin
        logic [Q_W-1:0] s [2];
        logic [18:0]    vh [2];
        logic [19:0]    vl [2];
        logic [80:0]    tot [2];
        for (int l = 0; l < 2; l++)
        begin
            q_next[l]  = Q_W'(md_reg[l]) * Q_W'(inv_reg[l]);
            s[l]       = q_reg[l] + XY_HALF;
            vq_next[l] = s[l][Q_W-1:XY_SHIFT];
            vh[l]      = vq_reg[l][38:20];
            vl[l]      = vq_reg[l][19:0];
            hh_next[l] = 39'(vh[l]) * 39'(RQ_HI);
            hl_next[l] = 40'(vh[l]) * 40'(RQ_LO);
            lh_next[l] = 40'(vl[l]) * 40'(RQ_HI);
            ll_next[l] = 41'(vl[l]) * 41'(RQ_LO);
            a_next[l]  = 61'({hh_reg[l], 21'd0}) + 61'(hl_reg[l]);
            b_next[l]  = 62'({lh_reg[l], 21'd0}) + 62'(ll_reg[l]);
            tot[l]     = 81'({a_reg[l], 20'd0}) + 81'(b_reg[l]);
            m_next[l]  = tot[l][RQ_SHIFT +: M_W];
        end
    end

    always_comb
    begin
        logic signed [P_W-1:0] pm [2];
        for (int l = 0; l < 2; l++)
        begin
            pm[l] = $signed({1'b0, m_reg[l]});
        end
        // Camera y points up, so its sign is the opposite of the row offset.
        p_next[0] = neg_reg[7][0] ? -pm[0] : pm[0];
        p_next[1] = neg_reg[7][1] ? pm[1] : -pm[1];
        p_next[2] = $signed({{(P_W - PZ_W){1'b0}}, pz_reg[7]});
    end

    always_comb
    begin
        logic signed [15:0]      rc;
        logic signed [ACC_W-1:0] bias;
        logic signed [ACC_W-1:0] biased;
        logic signed [31:0]      t_val [3];
        logic signed [SUM_W-1:0] sum;
        logic signed [31:0]      sat [3];
        t_val[0] = $signed(txy_reg[31:0]);
        t_val[1] = $signed(txy_reg[63:32]);
        t_val[2] = $signed(tz_reg);
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rc = $signed(rot_reg[i][16 * k +: 16]);
                prod_next[i][k] = PROD_W'(rc) * PROD_W'(p_reg[k]);
            end
            acc_next[i] = ACC_W'(prod_reg[i][0]) + ACC_W'(prod_reg[i][1])
                        + ACC_W'(prod_reg[i][2]);
            // Rounding half away from zero: negative sums take a bias one smaller.
            bias        = acc_reg[i][ACC_W-1] ? 52'sd8191 : 52'sd8192;
            biased      = acc_reg[i] + bias;
            rnd_next[i] = RND_W'(biased >>> 14);
            sum         = SUM_W'(rnd_reg[i]) + SUM_W'(t_val[i]);
            if (sum > SAT_MAX)
            begin
                sat[i] = 32'sh7FFF_FFFF;
            end
            else if (sum < SAT_MIN)
            begin
                sat[i] = 32'sh8000_0000;
            end
            else
            begin
                sat[i] = sum[31:0];
            end
        end
        point_next.world_x     = sat[0];
        point_next.world_y     = sat[1];
        point_next.world_z     = sat[2];
        point_next.point_red   = rgb_reg[NUM_STAGES - 1].red;
        point_next.point_green = rgb_reg[NUM_STAGES - 1].green;
        point_next.point_blue  = rgb_reg[NUM_STAGES - 1].blue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            inv_reg[0]      <= INV_FOCAL_RST;
            inv_reg[1]      <= INV_FOCAL_RST;
            pp_reg          <= '0;
            rot_reg[0]      <= ROT_ROW0_RST;
            rot_reg[1]      <= ROT_ROW1_RST;
            rot_reg[2]      <= ROT_ROW2_RST;
            txy_reg         <= '0;
            tz_reg          <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                stage_valid_reg[1] <= in_valid;
            end
            if (adv[2])
            begin
                stage_valid_reg[2] <= stage_valid_reg[1] && keep;
            end
            for (int k = 3; k <= NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    stage_valid_reg[k] <= stage_valid_reg[k - 1];
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_INV_FOCAL_X:     inv_reg[0] <= cfg_data[31:0];
                    CFG_INV_FOCAL_Y:     inv_reg[1] <= cfg_data[31:0];
                    CFG_PRINCIPAL_POINT: pp_reg     <= cfg_data[31:0];
                    CFG_ROTATION_ROW0:   rot_reg[0] <= cfg_data[47:0];
                    CFG_ROTATION_ROW1:   rot_reg[1] <= cfg_data[47:0];
                    CFG_ROTATION_ROW2:   rot_reg[2] <= cfg_data[47:0];
                    CFG_TRANSLATION_XY:  txy_reg    <= cfg_data;
                    CFG_TRANSLATION_Z:   tz_reg     <= cfg_data[31:0];
                    default:             tz_reg     <= tz_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            row1_reg     <= pixel.pixel_row;
            col1_reg     <= pixel.pixel_col;
            depth1_reg   <= pixel.depth_mm;
            depth_ok_reg <= depth_ok_next;
            qrow_reg     <= qrow_next;
            qcol_reg     <= qcol_next;
            mag_reg      <= mag_next;
            neg_reg[1]   <= neg_next;
            rgb_reg[1]   <= rgb_next;
        end
        if (adv[2])
        begin
            md_reg    <= md_next;
            pz_reg[2] <= pz_next;
        end
        if (adv[3])
        begin
            q_reg <= q_next;
        end
        if (adv[4])
        begin
            vq_reg <= vq_next;
        end
        if (adv[5])
        begin
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            ll_reg <= ll_next;
        end
        if (adv[6])
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
        if (adv[7])
        begin
            m_reg <= m_next;
        end
        if (adv[8])
        begin
            p_reg <= p_next;
        end
        if (adv[9])
        begin
            prod_reg <= prod_next;
        end
        if (adv[10])
        begin
            acc_reg <= acc_next;
        end
        if (adv[11])
        begin
            rnd_reg <= rnd_next;
        end
        if (adv[12])
        begin
            point_reg <= point_next;
        end
        for (int k = 2; k <= NUM_STAGES - 1; k++)
        begin
            if (adv[k])
            begin
                rgb_reg[k] <= rgb_reg[k - 1];
            end
        end
        for (int k = 2; k <= 7; k++)
        begin
            if (adv[k])
            begin
                neg_reg[k] <= neg_reg[k - 1];
            end
        end
        for (int k = 3; k <= 7; k++)
        begin
            if (adv[k])
            begin
                pz_reg[k] <= pz_reg[k - 1];
            end
        end
    end

    // Input stalls only when the whole pipeline is full behind a blocked output.
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low while the pipeline can still move");

    // Kept depths of 10 mm to 10000 mm give a camera z of 655 to 655360 in Q16.16.
    a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg[8] |-> ((p_reg[2] >= 34'sd655) && (p_reg[2] <= 34'sd655360)))
        else $error("camera z outside the range of kept depths");

    // The reciprocal divide never yields a lateral magnitude of 2^32 or more.
    a_lateral_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg[7] |-> (!m_reg[0][M_W-1] && !m_reg[1][M_W-1]))
        else $error("lateral magnitude exceeds its bound");

    // A zero horizontal reciprocal leaves only the rounding offset before the divide.
    a_zero_focal: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg[4] && (inv_reg[0] == '0)) |-> (vq_reg[0] == V_ZERO_INV))
        else $error("zero reciprocal focal length does not give zero camera x");

endmodule
